// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the segmenter modules; empty under SYNTH
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// property must hold at every clock edge out of reset
`define SEG_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
		else $error("segmenter assertion failed");
// expression must never be true out of reset
`define SEG_NEVER(lbl, clk, rstn, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
		else $error("segmenter forbidden condition");
`else
`define SEG_ASSERT(lbl, clk, rstn, prop)
`define SEG_NEVER(lbl, clk, rstn, expr)
`endif
`endif

// ----- rtl/core/tlgs_pkg.sv -----
// ----------------------------------------------------------------------------
// tlgs_pkg
// Shared types and constants of the text line and glyph segmenter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package tlgs_pkg;

	localparam int PIX_W      = 8;
	localparam int TOP_W      = 10;
	localparam int HGT_W      = 11;
	localparam int LEFT_W     = 7;
	localparam int GW_W       = 8;
	localparam int OUT_DATA_W = 40;

	localparam int CFG_IDX_W = 1;
	localparam int CFG_W     = 11;
	localparam int IMG_W_W   = 8;
	localparam int IMG_H_W   = 11;

	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'd1;

	localparam logic [IMG_W_W-1:0] IMAGE_WIDTH_RST  = 8'd128;
	localparam logic [IMG_H_W-1:0] IMAGE_HEIGHT_RST = 11'd1024;

	localparam int MAX_BOXES = 64;
	localparam int BOX_CNT_W = $clog2(MAX_BOXES + 1);

	typedef struct packed {
		logic accept;
		logic sweep;
		logic scan;
		logic flush;
		logic fin;
	} cmd_t;

	typedef struct packed {
		logic close_now;
		logic sweep_done;
		logic out_free;
	} sts_t;

endpackage
`default_nettype wire

// ----- rtl/core/tlgs_ctrl.sv -----
// ----------------------------------------------------------------------------
// tlgs_ctrl
// Sequencer: pixel streaming, column sweeps, run flush and last box release
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module tlgs_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           s_tvalid,
	output logic                s_tready,
	input  tlgs_pkg::sts_t      sts,
	output tlgs_pkg::cmd_t      cmd
);
	import tlgs_pkg::*;

	typedef enum logic [2:0] {
		ST_CLR,
		ST_RUN,
		ST_WALK,
		ST_FLUSH,
		ST_FIN
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
		end else begin
			unique case (state_q)
				ST_CLR: begin
					if (sts.sweep_done) state_q <= ST_RUN;
				end
				ST_RUN: begin
					if (s_tvalid && sts.close_now) state_q <= ST_WALK;
				end
				ST_WALK: begin
					if (sts.sweep_done) state_q <= ST_FLUSH;
				end
				ST_FLUSH: begin
					if (sts.out_free) state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (sts.out_free) state_q <= ST_RUN;
				end
				default: state_q <= ST_CLR;
			endcase
		end
	end

	assign s_tready   = (state_q == ST_RUN);
	assign cmd.accept = (state_q == ST_RUN) && s_tvalid;
	assign cmd.sweep  = (state_q == ST_CLR) || (state_q == ST_WALK);
	assign cmd.scan   = (state_q == ST_WALK);
	assign cmd.flush  = (state_q == ST_FLUSH);
	assign cmd.fin    = (state_q == ST_FIN);

	`SEG_ASSERT(a_close_walk, clk, arst_n, (cmd.accept && sts.close_now) |=> (state_q == ST_WALK))
	`SEG_ASSERT(a_walk_cause, clk, arst_n, $rose(cmd.scan) |-> $past(cmd.accept && sts.close_now))
	`SEG_ASSERT(a_walk_flush, clk, arst_n, (cmd.scan && sts.sweep_done) |=> cmd.flush)

endmodule
`default_nettype wire

// ----- rtl/core/tlgs_dpath.sv -----
// ----------------------------------------------------------------------------
// tlgs_dpath
// Datapath: raster counters, column ink memory, run finder and output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module tlgs_dpath #(
	parameter int MAX_WIDTH  = 128,
	parameter int MAX_HEIGHT = 1024
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  tlgs_pkg::cmd_t                      cmd,
	output tlgs_pkg::sts_t                      sts,
	input  wire logic [tlgs_pkg::PIX_W-1:0]     pixel,
	input  wire logic                           cfg_we,
	input  wire logic [tlgs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [tlgs_pkg::CFG_W-1:0]     cfg_wdata,
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	output logic [tlgs_pkg::TOP_W-1:0]          glyph_top,
	output logic [tlgs_pkg::HGT_W-1:0]          glyph_height,
	output logic [tlgs_pkg::LEFT_W-1:0]         glyph_left,
	output logic [tlgs_pkg::GW_W-1:0]           glyph_width,
	output logic                                last_in_line
);
	import tlgs_pkg::*;

	localparam int CA = $clog2(MAX_WIDTH);
	localparam int XW = $clog2(MAX_WIDTH + 1);
	localparam int RA = $clog2(MAX_HEIGHT);
	localparam int YW = $clog2(MAX_HEIGHT + 1);

	// configuration
	logic [IMG_W_W-1:0] width_q;
	logic [IMG_H_W-1:0] height_q;
	logic [XW-1:0]      w_use;
	logic [YW-1:0]      h_use;

	// raster state
	logic [CA-1:0] col_q;
	logic [RA-1:0] row_q;
	logic          row_ink_q;
	logic          line_open_q;
	logic [RA-1:0] top_q;

	// column ink memory
	logic mem [MAX_WIDTH];
	logic          wr_en;
	logic [CA-1:0] wr_addr;
	logic          wr_data;

	// sweep and run finder
	logic [XW-1:0]        addr_q;
	logic                 addr_lt;
	logic                 rd_s1;
	logic [XW-1:0]        idx_s1;
	logic                 v_s1;
	logic                 in_run_q;
	logic [XW-1:0]        start_q;
	logic                 pend_v_q;
	logic [LEFT_W-1:0]    pend_left_q;
	logic [GW_W-1:0]      pend_width_q;
	logic [BOX_CNT_W-1:0] cnt_q;
	logic [RA-1:0]        walk_top_q;
	logic [YW-1:0]        walk_h_q;

	// output register
	logic              o_valid_q;
	logic [TOP_W-1:0]  o_top_q;
	logic [HGT_W-1:0]  o_h_q;
	logic [LEFT_W-1:0] o_left_q;
	logic [GW_W-1:0]   o_width_q;
	logic              o_last_q;

	// per pixel decode
	logic          ink_now;
	logic          ink_eff;
	logic          end_row;
	logic          end_img;
	logic [RA-1:0] top_eff;
	logic          close_now;
	logic [YW-1:0] close_h;
	logic [RA-1:0] close_top;

	// per column decode
	logic          adv;
	logic          scan_bit;
	logic          step_scan;
	logic          step_flush;
	logic          run_end;
	logic [XW-1:0] end_idx;
	logic [XW-1:0] run_len;
	logic          box_found;
	logic          emit;

	always_comb begin
		if (width_q == '0) begin
			w_use = XW'(1);
		end else if (32'(width_q) > MAX_WIDTH) begin
			w_use = XW'(MAX_WIDTH);
		end else begin
			w_use = XW'(width_q);
		end
		if (height_q == '0) begin
			h_use = YW'(1);
		end else if (32'(height_q) > MAX_HEIGHT) begin
			h_use = YW'(MAX_HEIGHT);
		end else begin
			h_use = YW'(height_q);
		end
	end

	assign ink_now   = (pixel != '0);
	assign ink_eff   = row_ink_q | ink_now;
	assign end_row   = !((XW'(col_q) + XW'(1)) < w_use);
	assign end_img   = !((YW'(row_q) + YW'(1)) < h_use);
	assign top_eff   = line_open_q ? top_q : row_q;
	assign close_now = end_row && (ink_eff ? end_img : line_open_q);
	assign close_h   = ink_eff ? (YW'(row_q) - YW'(top_eff) + YW'(1))
	                           : (YW'(row_q) - YW'(top_q));
	assign close_top = ink_eff ? top_eff : top_q;

	assign adv        = !o_valid_q || m_tready;
	assign addr_lt    = (addr_q < XW'(MAX_WIDTH));
	assign scan_bit   = rd_s1 && (idx_s1 < w_use);
	assign step_scan  = cmd.sweep && cmd.scan && adv && v_s1;
	assign step_flush = cmd.flush && adv;
	assign run_end    = in_run_q && ((step_scan && !scan_bit) || step_flush);
	assign end_idx    = step_flush ? w_use : idx_s1;
	assign run_len    = end_idx - start_q;
	assign box_found  = run_end && (cnt_q < BOX_CNT_W'(MAX_BOXES));
	assign emit       = pend_v_q && (box_found || (cmd.fin && adv));

	assign wr_en   = (cmd.accept && ink_now) || (cmd.sweep && adv && addr_lt);
	assign wr_addr = cmd.sweep ? addr_q[CA-1:0] : col_q;
	assign wr_data = !cmd.sweep;

	// memory and read register
	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		if (cmd.sweep && adv && addr_lt) begin
			rd_s1  <= mem[addr_q[CA-1:0]];
			idx_s1 <= addr_q;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q     <= IMAGE_WIDTH_RST;
			height_q    <= IMAGE_HEIGHT_RST;
			col_q       <= '0;
			row_q       <= '0;
			row_ink_q   <= 1'b0;
			line_open_q <= 1'b0;
			top_q       <= '0;
			addr_q      <= '0;
			v_s1        <= 1'b0;
			in_run_q    <= 1'b0;
			pend_v_q    <= 1'b0;
			cnt_q       <= '0;
			o_valid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_IMAGE_WIDTH:  width_q  <= cfg_wdata[IMG_W_W-1:0];
					CFG_IMAGE_HEIGHT: height_q <= cfg_wdata[IMG_H_W-1:0];
				endcase
			end

			if (cmd.accept) begin
				if (!end_row) begin
					col_q     <= col_q + CA'(1);
					row_ink_q <= ink_eff;
				end else begin
					col_q     <= '0;
					row_ink_q <= 1'b0;
					if (!end_img) begin
						row_q <= row_q + RA'(1);
						if (ink_eff) begin
							if (!line_open_q) begin
								line_open_q <= 1'b1;
								top_q       <= row_q;
							end
						end else begin
							line_open_q <= 1'b0;
						end
					end else begin
						row_q       <= '0;
						top_q       <= '0;
						line_open_q <= 1'b0;
					end
				end
				if (close_now) begin
					addr_q   <= '0;
					v_s1     <= 1'b0;
					in_run_q <= 1'b0;
					pend_v_q <= 1'b0;
					cnt_q    <= '0;
				end
			end else begin
				if (cmd.sweep && adv) begin
					if (addr_lt) begin
						addr_q <= addr_q + XW'(1);
						v_s1   <= 1'b1;
					end else begin
						v_s1 <= 1'b0;
					end
				end
				if (step_scan && scan_bit && !in_run_q) in_run_q <= 1'b1;
				if (run_end) in_run_q <= 1'b0;
				if (box_found) begin
					cnt_q    <= cnt_q + BOX_CNT_W'(1);
					pend_v_q <= 1'b1;
				end
				if (cmd.fin && adv) pend_v_q <= 1'b0;
			end

			if (emit) begin
				o_valid_q <= 1'b1;
			end else if (m_tready) begin
				o_valid_q <= 1'b0;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (cmd.accept && close_now) begin
			walk_top_q <= close_top;
			walk_h_q   <= close_h;
		end
		if (step_scan && scan_bit && !in_run_q) start_q <= idx_s1;
		if (box_found) begin
			pend_left_q  <= LEFT_W'(start_q);
			pend_width_q <= GW_W'(run_len);
		end
		if (emit) begin
			o_top_q   <= TOP_W'(walk_top_q);
			o_h_q     <= HGT_W'(walk_h_q);
			o_left_q  <= pend_left_q;
			o_width_q <= pend_width_q;
			o_last_q  <= cmd.fin;
		end
	end

	assign sts.close_now  = close_now;
	assign sts.sweep_done = (addr_q == XW'(MAX_WIDTH)) && !v_s1;
	assign sts.out_free   = adv;

	assign m_tvalid     = o_valid_q;
	assign glyph_top    = o_top_q;
	assign glyph_height = o_h_q;
	assign glyph_left   = o_left_q;
	assign glyph_width  = o_width_q;
	assign last_in_line = o_last_q;

	`SEG_NEVER(a_emit_busy, clk, arst_n, emit && o_valid_q && !m_tready)
	`SEG_NEVER(a_acc_sweep, clk, arst_n, cmd.accept && cmd.sweep)
	`SEG_ASSERT(a_cnt_bound, clk, arst_n, cnt_q <= BOX_CNT_W'(MAX_BOXES))

endmodule
`default_nettype wire

// ----- rtl/core/text_line_and_glyph_segmenter_unit.sv -----
// ----------------------------------------------------------------------------
// text_line_and_glyph_segmenter_unit
// Projection profile segmentation of a binarized raster image into glyph boxes
// ----------------------------------------------------------------------------
// channel   dir  handshake           payload
// s_*       in   s_tvalid/s_tready   s_tdata: pixel
// m_*       out  m_tvalid/m_tready   m_tdata: glyph box, m_tlast: last_in_line
// cfg_*     in   cfg_we              cfg_index, cfg_wdata
//
// one pixel per cycle while streaming
// a line close runs the column sweep, flush and last box release, which stall
// while the output side holds m_tready low
// after reset a clearing pass zeroes the column memory with s_tready low;
// configuration writes are taken at any time
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module text_line_and_glyph_segmenter_unit #(
	parameter int MAX_WIDTH  = 128,
	parameter int MAX_HEIGHT = 1024
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	// pixel[7:0]
	input  wire logic [tlgs_pkg::PIX_W-1:0]      s_tdata,
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	// glyph_top[9:0], glyph_height[20:10], glyph_left[27:21], glyph_width[35:28]
	output logic [tlgs_pkg::OUT_DATA_W-1:0]      m_tdata,
	output logic                                 m_tlast,
	input  wire logic                            cfg_we,
	input  wire logic [tlgs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [tlgs_pkg::CFG_W-1:0]      cfg_wdata
);
	import tlgs_pkg::*;

	localparam int PAD_W = OUT_DATA_W - TOP_W - HGT_W - LEFT_W - GW_W;

	cmd_t cmd;
	sts_t sts;

	logic [TOP_W-1:0]  glyph_top;
	logic [HGT_W-1:0]  glyph_height;
	logic [LEFT_W-1:0] glyph_left;
	logic [GW_W-1:0]   glyph_width;

	tlgs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	tlgs_dpath #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.pixel        (s_tdata),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.glyph_top    (glyph_top),
		.glyph_height (glyph_height),
		.glyph_left   (glyph_left),
		.glyph_width  (glyph_width),
		.last_in_line (m_tlast)
	);

	assign m_tdata = {{PAD_W{1'b0}}, glyph_width, glyph_left, glyph_height, glyph_top};

endmodule
`default_nettype wire
